// ----- rtl/core/sitrs_pkg.sv -----
`default_nettype none

package sitrs_pkg;

  localparam int MAX_SYMBOLS = 16;
  localparam int MAX_DIGITS  = 32;
  localparam int MAG_W       = 32;
  localparam int RADIX_W     = 5;
  localparam int SYM_W       = 8;
  localparam int DIG_W       = 4;
  localparam int CNT_W       = 6;
  localparam int DATA_W      = 64;
  localparam int ADDR_W      = 5;
  localparam int REG_IDX_W   = 2;

  localparam logic [REG_IDX_W-1:0] REG_RADIX  = 2'd0;
  localparam logic [REG_IDX_W-1:0] REG_SYM_LO = 2'd1;
  localparam logic [REG_IDX_W-1:0] REG_SYM_HI = 2'd2;

  localparam logic [SYM_W-1:0] CH_MINUS = 8'h2D;
  localparam logic [SYM_W-1:0] CH_PLUS  = 8'h2B;
  localparam logic [SYM_W-1:0] CH_SPACE = 8'h20;
  localparam logic [SYM_W-1:0] CH_WS_LO = 8'd9;
  localparam logic [SYM_W-1:0] CH_WS_HI = 8'd13;

  typedef struct packed {
    logic             neg;
    logic [MAG_W-1:0] mag;
  } item_t;

  function automatic logic [SYM_W-1:0] sym_at(input logic [DATA_W-1:0] lo,
                                               input logic [DATA_W-1:0] hi,
                                               input logic [DIG_W-1:0]  pos);
    logic [DATA_W-1:0] w;
    w = pos[3] ? hi : lo;
    return w[{pos[2:0], 3'b000} +: SYM_W];
  endfunction

  function automatic logic sym_forbidden(input logic [SYM_W-1:0] s);
    return (s == '0) || (s == CH_PLUS) || (s == CH_MINUS) ||
           ((s >= CH_WS_LO) && (s <= CH_WS_HI)) || (s == CH_SPACE);
  endfunction

  // floor(2^32 / r); the quotient estimate from it is low by at most one
  function automatic logic [MAG_W-1:0] recip(input logic [RADIX_W-1:0] r);
    logic [MAG_W-1:0] v;
    case (r)
      5'd2:    v = 32'h8000_0000;
      5'd3:    v = 32'h5555_5555;
      5'd4:    v = 32'h4000_0000;
      5'd5:    v = 32'h3333_3333;
      5'd6:    v = 32'h2AAA_AAAA;
      5'd7:    v = 32'h2492_4924;
      5'd8:    v = 32'h2000_0000;
      5'd9:    v = 32'h1C71_C71C;
      5'd10:   v = 32'h1999_9999;
      5'd11:   v = 32'h1745_D174;
      5'd12:   v = 32'h1555_5555;
      5'd13:   v = 32'h13B1_3B13;
      5'd14:   v = 32'h1249_2492;
      5'd15:   v = 32'h1111_1111;
      5'd16:   v = 32'h1000_0000;
      default: v = '0;
    endcase
    return v;
  endfunction

endpackage

`default_nettype wire

// ----- rtl/core/sitrs_front.sv -----
`default_nettype none

module sitrs_front (
  input  wire logic                                in_valid,
  input  wire logic signed [sitrs_pkg::MAG_W-1:0]  in_value,
  output logic                                     in_stall,
  input  wire logic [sitrs_pkg::RADIX_W-1:0]       radix,
  input  wire logic [sitrs_pkg::DATA_W-1:0]        sym_lo,
  input  wire logic [sitrs_pkg::DATA_W-1:0]        sym_hi,
  input  wire logic                                q_full,
  output logic                                     push,
  output sitrs_pkg::item_t                         push_item
);

  logic                          alpha_ok;
  logic [sitrs_pkg::SYM_W-1:0]   syms [sitrs_pkg::MAX_SYMBOLS];
  logic [sitrs_pkg::MAG_W-1:0]   raw;

  // alphabet check over all symbol pairs in use; follows the registers directly,
  // so a request right after a register write sees the new alphabet
  always_comb begin
    for (int i = 0; i < sitrs_pkg::MAX_SYMBOLS; i++) begin
      syms[i] = sitrs_pkg::sym_at(sym_lo, sym_hi, sitrs_pkg::DIG_W'(i));
    end
    alpha_ok = (radix >= 5'd2) &&
               (radix <= sitrs_pkg::RADIX_W'(sitrs_pkg::MAX_SYMBOLS));
    for (int i = 0; i < sitrs_pkg::MAX_SYMBOLS; i++) begin
      if (sitrs_pkg::RADIX_W'(i) < radix) begin
        if (sitrs_pkg::sym_forbidden(syms[i])) begin
          alpha_ok = 1'b0;
        end
        for (int j = i + 1; j < sitrs_pkg::MAX_SYMBOLS; j++) begin
          if ((sitrs_pkg::RADIX_W'(j) < radix) && (syms[j] == syms[i])) begin
            alpha_ok = 1'b0;
          end
        end
      end
    end
  end

  // two's complement magnitude; 0x8000_0000 maps onto itself
  assign raw            = in_value;
  assign in_stall       = q_full;
  assign push           = in_valid && !q_full && alpha_ok;
  assign push_item.neg  = raw[sitrs_pkg::MAG_W-1];
  assign push_item.mag  = raw[sitrs_pkg::MAG_W-1] ? (~raw + 32'd1) : raw;

endmodule

`default_nettype wire

// ----- rtl/core/sitrs_queue.sv -----
`default_nettype none

module sitrs_queue #(
  parameter int DEPTH = 2
) (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              push,
  input  wire sitrs_pkg::item_t  push_item,
  output logic                   full,
  input  wire logic              pop,
  output logic                   pop_valid,
  output sitrs_pkg::item_t       pop_item
);

  localparam int PTR_W = $clog2(DEPTH);
  localparam int CNT_W = $clog2(DEPTH + 1);

  sitrs_pkg::item_t   mem_r [DEPTH];
  logic [PTR_W-1:0]   wr_ptr_r, wr_ptr_nxt;
  logic [PTR_W-1:0]   rd_ptr_r, rd_ptr_nxt;
  logic [CNT_W-1:0]   count_r, count_nxt;

  assign full      = (count_r == CNT_W'(DEPTH));
  assign pop_valid = (count_r != '0);
  assign pop_item  = mem_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (push) begin
      wr_ptr_nxt = (wr_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
    end
    if (pop) begin
      rd_ptr_nxt = (rd_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
    end
    if (push && !pop) begin
      count_nxt = count_r + 1'b1;
    end else if (pop && !push) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= push_item;
    end
  end

  a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    push |-> (!full || pop))
    else $error("queue push while full");

  a_no_underflow: assert property (@(posedge clk) disable iff (!rst_n)
    pop |-> pop_valid)
    else $error("queue pop while empty");

endmodule

`default_nettype wire

// ----- rtl/core/sitrs_back.sv -----
`default_nettype none

module sitrs_back (
  input  wire logic                              clk,
  input  wire logic                              rst_n,
  input  wire logic [sitrs_pkg::RADIX_W-1:0]     radix,
  input  wire logic [sitrs_pkg::DATA_W-1:0]      sym_lo,
  input  wire logic [sitrs_pkg::DATA_W-1:0]      sym_hi,
  input  wire logic                              q_valid,
  input  wire sitrs_pkg::item_t                  q_item,
  output logic                                   q_pop,
  output logic                                   out_valid,
  input  wire logic                              out_stall,
  output logic [sitrs_pkg::SYM_W-1:0]            out_symbol,
  output logic                                   out_last
);

  typedef enum logic [3:0] {
    ST_IDLE = 4'b0001,
    ST_MUL  = 4'b0010,
    ST_FIX  = 4'b0100,
    ST_EMIT = 4'b1000
  } state_t;

  state_t                          state_r, state_nxt;
  logic [sitrs_pkg::MAG_W-1:0]     mag_r, mag_nxt;
  logic [sitrs_pkg::MAG_W-1:0]     q0_r, q0_nxt;
  logic                            sign_r, sign_nxt;
  logic [sitrs_pkg::CNT_W-1:0]     nd_r, nd_nxt;
  logic [sitrs_pkg::DIG_W-1:0]     dig_buf_r [sitrs_pkg::MAX_DIGITS];
  logic                            out_valid_r, out_valid_nxt;
  logic [sitrs_pkg::SYM_W-1:0]     out_symbol_r, out_symbol_nxt;
  logic                            out_last_r, out_last_nxt;

  logic [2*sitrs_pkg::MAG_W-1:0]   prod;
  logic [10:0]                     qr_lo;
  logic [5:0]                      rem6;
  logic                            rem_ge;
  logic [5:0]                      digit6;
  logic [sitrs_pkg::MAG_W-1:0]     q_fixed;
  logic                            dig_wr;
  logic [sitrs_pkg::CNT_W-1:0]     rd_idx;
  logic                            out_free;

  // quotient estimate: mag * floor(2^32/r) >> 32
  assign prod = {{sitrs_pkg::MAG_W{1'b0}}, mag_r} *
                {{sitrs_pkg::MAG_W{1'b0}}, sitrs_pkg::recip(radix)};

  // remainder is below 2*radix < 64, so six low bits carry it exactly
  assign qr_lo   = q0_r[5:0] * radix;
  assign rem6    = mag_r[5:0] - qr_lo[5:0];
  assign rem_ge  = (rem6 >= {1'b0, radix});
  assign digit6  = rem_ge ? (rem6 - {1'b0, radix}) : rem6;
  assign q_fixed = q0_r + sitrs_pkg::MAG_W'(rem_ge);

  assign out_free = !out_valid_r || !out_stall;
  assign rd_idx   = nd_r - 1'b1;

  always_comb begin
    state_nxt      = state_r;
    mag_nxt        = mag_r;
    q0_nxt         = q0_r;
    sign_nxt       = sign_r;
    nd_nxt         = nd_r;
    q_pop          = 1'b0;
    dig_wr         = 1'b0;
    out_valid_nxt  = out_valid_r && out_stall;
    out_symbol_nxt = out_symbol_r;
    out_last_nxt   = out_last_r;
    unique case (state_r)
      ST_IDLE: begin
        if (q_valid) begin
          q_pop     = 1'b1;
          mag_nxt   = q_item.mag;
          sign_nxt  = q_item.neg;
          nd_nxt    = '0;
          state_nxt = ST_MUL;
        end
      end
      ST_MUL: begin
        q0_nxt    = prod[2*sitrs_pkg::MAG_W-1:sitrs_pkg::MAG_W];
        state_nxt = ST_FIX;
      end
      ST_FIX: begin
        dig_wr    = 1'b1;
        nd_nxt    = nd_r + 1'b1;
        mag_nxt   = q_fixed;
        state_nxt = (q_fixed == '0) ? ST_EMIT : ST_MUL;
      end
      ST_EMIT: begin
        if (out_free) begin
          out_valid_nxt = 1'b1;
          if (sign_r) begin
            out_symbol_nxt = sitrs_pkg::CH_MINUS;
            out_last_nxt   = 1'b0;
            sign_nxt       = 1'b0;
          end else begin
            out_symbol_nxt = sitrs_pkg::sym_at(sym_lo, sym_hi,
                                               dig_buf_r[rd_idx[4:0]]);
            out_last_nxt   = (nd_r == sitrs_pkg::CNT_W'(1));
            nd_nxt         = rd_idx;
            if (nd_r == sitrs_pkg::CNT_W'(1)) begin
              state_nxt = ST_IDLE;
            end
          end
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      sign_r      <= 1'b0;
      nd_r        <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      sign_r      <= sign_nxt;
      nd_r        <= nd_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    mag_r        <= mag_nxt;
    q0_r         <= q0_nxt;
    out_symbol_r <= out_symbol_nxt;
    out_last_r   <= out_last_nxt;
    if (dig_wr) begin
      dig_buf_r[nd_r[4:0]] <= digit6[sitrs_pkg::DIG_W-1:0];
    end
  end

  assign out_valid  = out_valid_r;
  assign out_symbol = out_symbol_r;
  assign out_last   = out_last_r;

  a_idle_empty: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_IDLE) |-> (nd_r == '0))
    else $error("digits left over in idle");

  a_digit_range: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_FIX) |-> (digit6 < {1'b0, radix}))
    else $error("corrected remainder not below radix");

  a_digit_count: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_FIX) |-> (nd_r < sitrs_pkg::CNT_W'(sitrs_pkg::MAX_DIGITS)))
    else $error("digit buffer overrun");

endmodule

`default_nettype wire

// ----- rtl/core/signed_int_to_radix_symbols_top.sv -----
// Per digit: a reciprocal multiply state, then a one-step correction state;
//   then the sign and digits go out, one symbol per cycle while out_stall is low.
// The shared divide loop takes a new value from the queue only when idle, so it
//   works on one value at a time; the queue keeps accepting requests until full.
// Reset: rst_n synchronous, active low; clears the config registers to 0, so the
//   alphabet is invalid and requests are dropped until radix and symbols are written.
`default_nettype none

module signed_int_to_radix_symbols_top #(
  parameter int QUEUE_DEPTH = 2
) (
  input  wire logic                                clk,
  input  wire logic                                rst_n,
  // input request channel
  input  wire logic                                in_valid,
  output logic                                     in_stall,
  input  wire logic signed [sitrs_pkg::MAG_W-1:0]  in_value,
  // symbol channel
  output logic                                     out_valid,
  input  wire logic                                out_stall,
  output logic [sitrs_pkg::SYM_W-1:0]              out_symbol,
  output logic                                     out_last,
  // register port, 64-bit registers at 8-byte strides
  input  wire logic                                psel,
  input  wire logic                                penable,
  input  wire logic                                pwrite,
  input  wire logic [sitrs_pkg::ADDR_W-1:0]        paddr,
  input  wire logic [sitrs_pkg::DATA_W-1:0]        pwdata,
  output logic [sitrs_pkg::DATA_W-1:0]             prdata,
  output logic                                     pready
);

  logic [sitrs_pkg::RADIX_W-1:0]   radix_r;
  logic [sitrs_pkg::DATA_W-1:0]    sym_lo_r;
  logic [sitrs_pkg::DATA_W-1:0]    sym_hi_r;
  logic                            reg_wr;
  logic [sitrs_pkg::REG_IDX_W-1:0] reg_idx;

  logic                            q_full;
  logic                            q_push;
  sitrs_pkg::item_t                q_push_item;
  logic                            q_pop;
  logic                            q_valid;
  sitrs_pkg::item_t                q_item;

  // ---------------------------------------------------------------
  // register file: byte address bits [2:0] ignored, unknown index
  // writes dropped, reads of unknown index return zero
  // ---------------------------------------------------------------
  assign pready  = 1'b1;
  assign reg_idx = paddr[sitrs_pkg::ADDR_W-1:3];
  assign reg_wr  = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      radix_r  <= '0;
      sym_lo_r <= '0;
      sym_hi_r <= '0;
    end else if (reg_wr) begin
      unique case (reg_idx)
        sitrs_pkg::REG_RADIX:  radix_r  <= pwdata[sitrs_pkg::RADIX_W-1:0];
        sitrs_pkg::REG_SYM_LO: sym_lo_r <= pwdata;
        sitrs_pkg::REG_SYM_HI: sym_hi_r <= pwdata;
        default: begin
        end
      endcase
    end
  end

  always_comb begin
    unique case (reg_idx)
      sitrs_pkg::REG_RADIX:  prdata = sitrs_pkg::DATA_W'(radix_r);
      sitrs_pkg::REG_SYM_LO: prdata = sym_lo_r;
      sitrs_pkg::REG_SYM_HI: prdata = sym_hi_r;
      default:               prdata = '0;
    endcase
  end

  // ---------------------------------------------------------------
  // front: checks alphabet straight from the registers, takes the
  // magnitude, drops requests when the alphabet is bad
  // ---------------------------------------------------------------
  sitrs_front u_front (
    .in_valid  (in_valid),
    .in_value  (in_value),
    .in_stall  (in_stall),
    .radix     (radix_r),
    .sym_lo    (sym_lo_r),
    .sym_hi    (sym_hi_r),
    .q_full    (q_full),
    .push      (q_push),
    .push_item (q_push_item)
  );

  // short queue decouples acceptance from the digit loop
  sitrs_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (q_push),
    .push_item (q_push_item),
    .full      (q_full),
    .pop       (q_pop),
    .pop_valid (q_valid),
    .pop_item  (q_item)
  );

  // ---------------------------------------------------------------
  // back: digit loop (LSD first into a buffer), then sign and digits
  // out MSD first through a registered output stage
  // ---------------------------------------------------------------
  sitrs_back u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .radix      (radix_r),
    .sym_lo     (sym_lo_r),
    .sym_hi     (sym_hi_r),
    .q_valid    (q_valid),
    .q_item     (q_item),
    .q_pop      (q_pop),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .out_symbol (out_symbol),
    .out_last   (out_last)
  );

endmodule

`default_nettype wire

// ----- test/tb_signed_int_to_radix_symbols_top.sv -----
`timescale 1ns / 1ps

module tb_signed_int_to_radix_symbols_top;

  // The worst case per value is -2^31 in radix 2, with 33 symbols out.
  // Random stalls add little to that, so this limit leaves plenty of margin.
  localparam int CYCLE_LIMIT  = 400_000;
  // A request against a bad alphabet is dropped at the input and yields no
  // symbols. This margin lets the block settle before the registers change.
  localparam int DRAIN_CYCLES = 120;

  // There is no register at this index. A write there must change nothing.
  localparam logic [sitrs_pkg::REG_IDX_W-1:0] REG_SPARE = 2'd3;

  // Alphabet symbol 0 is in the low byte, so "76543210" maps digit d to 'd'.
  localparam logic [sitrs_pkg::DATA_W-1:0] DEC_LO = "76543210";
  localparam logic [sitrs_pkg::DATA_W-1:0] DEC_HI = 64'h3938;
  localparam logic [sitrs_pkg::DATA_W-1:0] HEX_HI = "FEDCBA98";
  localparam logic [sitrs_pkg::DATA_W-1:0] BIN_LO = 64'h3130;

  typedef struct packed {
    logic [sitrs_pkg::SYM_W-1:0] symbol;
    logic                        last;
  } sym_rec_t;

  logic                                clk;
  logic                                rst_n    = 1'b0;
  logic                                in_valid = 1'b0;
  logic                                in_stall;
  logic signed [sitrs_pkg::MAG_W-1:0]  in_value = '0;
  logic                                out_valid;
  logic                                out_stall = 1'b0;
  logic [sitrs_pkg::SYM_W-1:0]         out_symbol;
  logic                                out_last;
  logic                                psel     = 1'b0;
  logic                                penable  = 1'b0;
  logic                                pwrite   = 1'b0;
  logic [sitrs_pkg::ADDR_W-1:0]        paddr    = '0;
  logic [sitrs_pkg::DATA_W-1:0]        pwdata   = '0;
  logic [sitrs_pkg::DATA_W-1:0]        prdata;
  logic                                pready;

  // Copy of the register file, updated whenever the bus writes.
  logic [sitrs_pkg::RADIX_W-1:0]       radix_q  = '0;
  logic [sitrs_pkg::DATA_W-1:0]        sym_lo_q = '0;
  logic [sitrs_pkg::DATA_W-1:0]        sym_hi_q = '0;

  logic signed [sitrs_pkg::MAG_W-1:0]  values_pending[$];  // requests not yet offered
  sym_rec_t                            symbols_due[$];     // symbols still to come
  int                                  mismatches = 0;
  int                                  cycles     = 0;
  logic                                steady     = 1'b0;  // no random idling or stalling

  signed_int_to_radix_symbols_top i_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_value  (in_value),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_symbol(out_symbol),
    .out_last  (out_last),
    .psel      (psel),
    .penable   (penable),
    .pwrite    (pwrite),
    .paddr     (paddr),
    .pwdata    (pwdata),
    .prdata    (prdata),
    .pready    (pready)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // ---------------------------------------------------------------------------
  // Prediction
  // ---------------------------------------------------------------------------

  function automatic logic [sitrs_pkg::SYM_W-1:0] symbol_at(
      input logic [sitrs_pkg::DATA_W-1:0] lo,
      input logic [sitrs_pkg::DATA_W-1:0] hi,
      input int pos);
    return (pos < 8) ? lo[pos*8 +: sitrs_pkg::SYM_W] : hi[(pos-8)*8 +: sitrs_pkg::SYM_W];
  endfunction

  // The symbol 0 counts as reserved too, because a C string would end there.
  function automatic logic is_reserved_symbol(input logic [sitrs_pkg::SYM_W-1:0] s);
    return (s == 8'h00) || (s == sitrs_pkg::CH_PLUS) || (s == sitrs_pkg::CH_MINUS) ||
           (s == sitrs_pkg::CH_SPACE) ||
           ((s >= sitrs_pkg::CH_WS_LO) && (s <= sitrs_pkg::CH_WS_HI));
  endfunction

  // radix_q must be 2..16, and each symbol in use must be allowed and unique.
  // Symbols at positions of radix_q and up are ignored.
  function automatic logic alphabet_valid();
    int r;
    r = radix_q;
    if (r < 2 || r > sitrs_pkg::MAX_SYMBOLS) return 1'b0;
    for (int i = 0; i < r; i++) begin
      if (is_reserved_symbol(symbol_at(sym_lo_q, sym_hi_q, i))) return 1'b0;
      for (int j = i + 1; j < r; j++) begin
        if (symbol_at(sym_lo_q, sym_hi_q, j) == symbol_at(sym_lo_q, sym_hi_q, i))
          return 1'b0;
      end
    end
    return 1'b1;
  endfunction

  // Queues the symbols that one accepted request must produce, in order.
  // The magnitude is kept in 64 bits, so -2^31 takes no special path.
  function automatic void predict_symbols(input logic signed [sitrs_pkg::MAG_W-1:0] v);
    logic [sitrs_pkg::SYM_W-1:0] digs[$];
    longint                      mag;
    int                          r;
    sym_rec_t                    rec;
    r = radix_q;
    if (!alphabet_valid()) return;
    mag = v;
    if (mag < 0) mag = -mag;
    // Digits come out least significant first; push_front puts them in print order.
    do begin
      digs.push_front(symbol_at(sym_lo_q, sym_hi_q, int'(mag % r)));
      mag = mag / r;
    end while (mag != 0);
    if (v < 0) begin
      rec.symbol = sitrs_pkg::CH_MINUS;
      rec.last   = 1'b0;
      symbols_due.push_back(rec);
    end
    while (digs.size() > 0) begin
      rec.symbol = digs.pop_front();
      rec.last   = (digs.size() == 0);
      symbols_due.push_back(rec);
    end
  endfunction

  // ---------------------------------------------------------------------------
  // Request driver: takes values from values_pending and idles at random unless steady.
  // A stalled request keeps its payload. in_valid gets at most one assignment per edge.
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin
    if (rst_n) begin
      if (in_valid && !in_stall) predict_symbols(in_value);
      if (!in_valid || !in_stall) begin
        if (values_pending.size() > 0 && (steady || $urandom_range(99) >= 14)) begin
          in_value <= values_pending.pop_front();
          in_valid <= 1'b1;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Symbol monitor: compares each accepted symbol with the oldest one due,
  // then picks this edge's stall at random unless steady is set.
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin : watch_symbols
    sym_rec_t want;
    if (rst_n) begin
      if (out_valid && !out_stall) begin
        if (symbols_due.size() == 0) begin
          $error("symbol %h (last %0b) arrived with none due", out_symbol, out_last);
          mismatches++;
        end else begin
          want = symbols_due.pop_front();
          if (out_symbol !== want.symbol) begin
            $error("symbol: expected %h, actual %h", want.symbol, out_symbol);
            mismatches++;
          end
          if (out_last !== want.last) begin
            $error("last: expected %0b, actual %0b", want.last, out_last);
            mismatches++;
          end
        end
      end
      out_stall <= !steady && ($urandom_range(99) < 14);
    end
  end

  // Timeout guard
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= CYCLE_LIMIT) begin
      $display("Mismatches found");
      $finish;
    end
  end

  // ---------------------------------------------------------------------------
  // Register access and stimulus helpers
  // ---------------------------------------------------------------------------

  // Setup phase, then access phase. The write takes effect on the edge where
  // pready is high in the access phase. The registers sit 8 bytes apart.
  task automatic write_reg(input logic [sitrs_pkg::REG_IDX_W-1:0] idx,
                           input logic [sitrs_pkg::DATA_W-1:0] data);
    @(posedge clk);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 3'b000};
    pwdata  <= data;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    case (idx)
      sitrs_pkg::REG_RADIX:  radix_q  = data[sitrs_pkg::RADIX_W-1:0];
      sitrs_pkg::REG_SYM_LO: sym_lo_q = data;
      sitrs_pkg::REG_SYM_HI: sym_hi_q = data;
      default: ;
    endcase
  endtask

  // The radix write also puts random junk in the unused upper bits.
  task automatic set_alphabet(input int r, input logic [sitrs_pkg::DATA_W-1:0] lo,
                              input logic [sitrs_pkg::DATA_W-1:0] hi);
    logic [sitrs_pkg::DATA_W-1:0] rword;
    rword = {$urandom, $urandom};
    rword[sitrs_pkg::RADIX_W-1:0] = r[sitrs_pkg::RADIX_W-1:0];
    write_reg(sitrs_pkg::REG_RADIX, rword);
    write_reg(sitrs_pkg::REG_SYM_LO, lo);
    write_reg(sitrs_pkg::REG_SYM_HI, hi);
  endtask

  task automatic put_symbol(inout logic [sitrs_pkg::DATA_W-1:0] lo,
                            inout logic [sitrs_pkg::DATA_W-1:0] hi,
                            input int pos, input logic [sitrs_pkg::SYM_W-1:0] s);
    if (pos < 8) lo[pos*8 +: sitrs_pkg::SYM_W] = s;
    else         hi[(pos-8)*8 +: sitrs_pkg::SYM_W] = s;
  endtask

  function automatic logic [sitrs_pkg::SYM_W-1:0] bad_symbol(input int k);
    case (k)
      0:       return 8'h00;
      1:       return sitrs_pkg::CH_PLUS;
      2:       return sitrs_pkg::CH_MINUS;
      3:       return sitrs_pkg::CH_SPACE;
      default: return sitrs_pkg::CH_WS_LO + sitrs_pkg::SYM_W'(k - 4);  // 9 .. 13
    endcase
  endfunction

  // Random distinct allowed symbols at positions below r, random junk above.
  task automatic make_alphabet(input int r, output logic [sitrs_pkg::DATA_W-1:0] lo,
                               output logic [sitrs_pkg::DATA_W-1:0] hi);
    logic [255:0]                used;
    logic [sitrs_pkg::SYM_W-1:0] s;
    used = '0;
    lo   = {$urandom, $urandom};
    hi   = {$urandom, $urandom};
    for (int i = 0; i < r; i++) begin
      do s = sitrs_pkg::SYM_W'($urandom_range(255));
      while (is_reserved_symbol(s) || used[s]);
      used[s] = 1'b1;
      put_symbol(lo, hi, i, s);
    end
  endtask

  // Breaks a valid alphabet: radix too small or too large, a duplicate, or a
  // reserved symbol.
  task automatic spoil_alphabet(inout int r, inout logic [sitrs_pkg::DATA_W-1:0] lo,
                                inout logic [sitrs_pkg::DATA_W-1:0] hi);
    int i;
    int j;
    i = $urandom_range(r - 1);
    j = $urandom_range(r - 1);
    if (j == i) j = (i + 1) % r;
    case ($urandom_range(3))
      0:       r = $urandom_range(1);
      1:       r = $urandom_range(31, sitrs_pkg::MAX_SYMBOLS + 1);
      2:       put_symbol(lo, hi, j, symbol_at(lo, hi, i));
      default: put_symbol(lo, hi, i, bad_symbol($urandom_range(8)));
    endcase
  endtask

  // Full-range values, small ones of both signs (few digits) and the extremes.
  function automatic logic signed [sitrs_pkg::MAG_W-1:0] rand_value();
    logic signed [sitrs_pkg::MAG_W-1:0] v;
    case ($urandom_range(4))
      0, 1: v = $urandom;
      2:    v = $urandom_range(300);
      3:    v = -int'($urandom_range(300, 1));
      default: begin
        case ($urandom_range(3))
          0:       v = 32'h8000_0000;
          1:       v = 32'h7FFF_FFFF;
          2:       v = '0;
          default: v = -1;
        endcase
      end
    endcase
    return v;
  endfunction

  task automatic send(input logic signed [sitrs_pkg::MAG_W-1:0] v);
    values_pending.push_back(v);
  endtask

  // Returns once the sender has nothing left, no symbol is due, and the
  // DRAIN_CYCLES margin has passed.
  task automatic wait_drained();
    @(negedge clk);
    while (values_pending.size() != 0 || in_valid || symbols_due.size() != 0)
      @(negedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);
  endtask

  // Queues n random values, then waits for the block to drain. The sender
  // stays silent until every symbol due has arrived.
  task automatic run_batch(input int n);
    repeat (n) send(rand_value());
    wait_drained();
  endtask

  // ---------------------------------------------------------------------------
  // Test sequence
  // ---------------------------------------------------------------------------
  initial begin
    logic [sitrs_pkg::DATA_W-1:0] lo;
    logic [sitrs_pkg::DATA_W-1:0] hi;
    int                           r;

    repeat (10) @(posedge clk);
    rst_n <= 1'b1;

    // After reset the registers are zero, which is not a valid alphabet, so
    // these requests yield nothing.
    send(5);
    send(-5);
    wait_drained();

    // Decimal: zero, one, the sign edges and both limits
    set_alphabet(10, DEC_LO, DEC_HI);
    send(0);
    send(1);
    send(-1);
    send(32'h7FFF_FFFF);
    send(32'h8000_0000);
    send(-10);
    wait_drained();

    // Binary. Junk above symbol 1 must be ignored. -2^31 is the longest run:
    // a minus sign plus 32 digits.
    set_alphabet(2, BIN_LO, '1);
    send(32'h8000_0000);
    send(32'h7FFF_FFFF);
    send(0);
    wait_drained();

    // Hex at the widest radix
    set_alphabet(16, DEC_LO, HEX_HI);
    send(-1);
    send(32'h1234_5678);
    send(32'h8000_0000);
    wait_drained();

    // Radix too small, radix too large, and radix 31 from an all-ones write
    set_alphabet(1, DEC_LO, DEC_HI);
    send(7);
    wait_drained();
    set_alphabet(sitrs_pkg::MAX_SYMBOLS + 1, DEC_LO, HEX_HI);
    send(7);
    wait_drained();
    write_reg(sitrs_pkg::REG_RADIX, '1);
    send(7);
    wait_drained();

    // Each reserved symbol in turn, placed inside the decimal alphabet
    for (int k = 0; k < 9; k++) begin
      lo = DEC_LO;
      hi = DEC_HI;
      put_symbol(lo, hi, 3, bad_symbol(k));
      set_alphabet(10, lo, hi);
      send(12345);
      wait_drained();
    end

    // Symbol 8 repeats symbol 0, across the two words
    set_alphabet(10, DEC_LO, 64'h3930);
    send(12345);
    wait_drained();

    // Random part: a new alphabet per phase, widest and narrowest radix first.
    // Every sixth phase gets a broken alphabet. Phase 3 runs without idling.
    for (int p = 0; p < 12; p++) begin
      r = (p == 0) ? sitrs_pkg::MAX_SYMBOLS : (p == 1) ? 2 :
          $urandom_range(sitrs_pkg::MAX_SYMBOLS, 2);
      make_alphabet(r, lo, hi);
      if (p % 6 == 5) spoil_alphabet(r, lo, hi);
      steady = (p == 3);
      set_alphabet(r, lo, hi);
      if (p == 0) write_reg(REG_SPARE, {$urandom, $urandom});
      run_batch(15);
      run_batch(15);
    end
    steady = 1'b0;

    if (symbols_due.size() != 0) begin
      $error("%0d symbols never arrived", symbols_due.size());
      mismatches += symbols_due.size();
    end
    if (mismatches == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule

// ----- signed_int_to_radix_symbols_top.f -----
rtl/core/sitrs_pkg.sv
rtl/core/sitrs_front.sv
rtl/core/sitrs_queue.sv
rtl/core/sitrs_back.sv
rtl/core/signed_int_to_radix_symbols_top.sv
test/tb_signed_int_to_radix_symbols_top.sv
